@@ sv/wvt_pkg.sv @@
`default_nettype none

package wvt_pkg;

   localparam int MAX_VERTICES    = 8;
   localparam int COORD_FRAC_BITS = 16;
   localparam int SCALE_FRAC_BITS = 16;
   localparam int TRIG_FRAC_BITS  = 14;

   localparam int VIDX_W   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int VCNT_W   = VIDX_W + 1;
   localparam int COORD_W  = 32;
   localparam int SCALE_W  = 24;
   localparam int TRIG_W   = 16;
   localparam int POINT_W  = 16;
   localparam int CENTER_W = 12;
   localparam int LINK_W   = 3;
   localparam int OPB_W    = SCALE_W + 1;
   localparam int PROD_W   = COORD_W + OPB_W;
   localparam int ACC_W    = PROD_W + 1;
   localparam int SCR_W    = ((COORD_W - COORD_FRAC_BITS) > POINT_W ?
                              (COORD_W - COORD_FRAC_BITS) : POINT_W) + 2;

   localparam int CUBE_VERTICES = 8;
   localparam int PYR_VERTICES  = 5;
   localparam int CUBE_POINTS   = 24;
   localparam int PYR_POINTS    = 16;
   localparam int K_W           = $clog2(CUBE_POINTS);
   localparam int PYR_K_W       = $clog2(PYR_POINTS);

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;

   localparam logic [CSR_IDX_W-1:0] REG_SHAPE_SELECT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET_X     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET_Y     = 2'd2;

   localparam logic                SHAPE_CUBE     = 1'b0;
   localparam logic                SHAPE_PYRAMID  = 1'b1;
   localparam logic [CENTER_W-1:0] OFFSET_X_RESET = 12'd160;
   localparam logic [CENTER_W-1:0] OFFSET_Y_RESET = 12'd120;

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_FRAME = 1'b1;

   localparam logic [LINK_W-1:0] CUBE_LINKS [CUBE_POINTS] = '{
      3'd0, 3'd1, 3'd1, 3'd3, 3'd3, 3'd2, 3'd2, 3'd0,
      3'd4, 3'd5, 3'd5, 3'd7, 3'd7, 3'd6, 3'd6, 3'd4,
      3'd0, 3'd4, 3'd1, 3'd5, 3'd2, 3'd6, 3'd3, 3'd7};

   localparam logic [LINK_W-1:0] PYR_LINKS [PYR_POINTS] = '{
      3'd0, 3'd1, 3'd1, 3'd2, 3'd2, 3'd3, 3'd3, 3'd0,
      3'd0, 3'd4, 3'd1, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_XFORM,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   typedef enum logic [3:0] {
      STEP_SCALE_X,
      STEP_SCALE_Y,
      STEP_SCALE_Z,
      STEP_ROT1_XC,
      STEP_ROT1_ZS,
      STEP_ROT1_ZC,
      STEP_ROT1_XS,
      STEP_ROT2_YC,
      STEP_ROT2_ZS,
      STEP_ROT2_ZC,
      STEP_ROT2_YS
   } step_type;

   typedef enum logic [2:0] {
      OPA_MEM_X,
      OPA_MEM_Y,
      OPA_MEM_Z,
      OPA_WX,
      OPA_WY,
      OPA_WZ
   } opa_type;

   typedef enum logic [2:0] {
      OPB_SCALE,
      OPB_COS1,
      OPB_SIN1,
      OPB_COS2,
      OPB_SIN2
   } opb_type;

   typedef enum logic [1:0] {
      ACC_NONE,
      ACC_LOAD,
      ACC_ADD,
      ACC_SUB
   } acc_op_type;

   typedef enum logic [2:0] {
      WB_NONE,
      WB_WX,
      WB_WY,
      WB_WZ,
      WB_MEM_X,
      WB_MEM_Y,
      WB_MEM_Z
   } wb_type;

   typedef struct packed {
      logic              capture;
      logic              load_unit;
      opa_type           opa;
      opb_type           opb;
      acc_op_type        acc_op;
      wb_type            wb;
      logic [VIDX_W-1:0] vidx;
      logic              emit;
      logic [K_W-1:0]    emit_k;
      logic              emit_last;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

   typedef struct packed {
      logic signed [1:0] x;
      logic signed [1:0] y;
      logic signed [1:0] z;
   } unit_type;

   function automatic logic [VCNT_W-1:0] vertex_count(input logic shape);
      int n;
      n = (shape == SHAPE_PYRAMID) ? PYR_VERTICES : CUBE_VERTICES;
      if (n > MAX_VERTICES) n = MAX_VERTICES;
      return VCNT_W'(n);
   endfunction

   function automatic logic [K_W-1:0] point_count(input logic shape);
      return (shape == SHAPE_PYRAMID) ? K_W'(PYR_POINTS) : K_W'(CUBE_POINTS);
   endfunction

   function automatic logic [LINK_W-1:0] link_vertex(input logic shape,
                                                     input logic [K_W-1:0] k);
      logic [LINK_W-1:0] v;
      if (shape == SHAPE_PYRAMID) v = PYR_LINKS[k[PYR_K_W-1:0]];
      else                        v = CUBE_LINKS[k];
      return v;
   endfunction

   // Cube corners follow the index bits (x, y, z); pyramid entries past the apex read zero.
   function automatic unit_type unit_vertex(input logic shape, input logic [LINK_W-1:0] v);
      unit_type u;
      u = '0;
      if (shape == SHAPE_CUBE) begin
         u.x = v[2] ? 2'sd1 : -2'sd1;
         u.y = v[1] ? 2'sd1 : -2'sd1;
         u.z = v[0] ? 2'sd1 : -2'sd1;
      end else begin
         case (v)
            3'd0: u = '{x: -2'sd1, y: -2'sd1, z: -2'sd1};
            3'd1: u = '{x:  2'sd1, y: -2'sd1, z: -2'sd1};
            3'd2: u = '{x:  2'sd1, y:  2'sd1, z: -2'sd1};
            3'd3: u = '{x: -2'sd1, y:  2'sd1, z: -2'sd1};
            3'd4: u = '{x:  2'sd0, y:  2'sd0, z:  2'sd1};
            default: u = '0;
         endcase
      end
      return u;
   endfunction

endpackage

`default_nettype wire

@@ sv/wvt_req_if.sv @@
`default_nettype none

interface wvt_req_if import wvt_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     req_type;
   logic [SCALE_W-1:0]       scale_factor;
   logic signed [TRIG_W-1:0] sin_first;
   logic signed [TRIG_W-1:0] cos_first;
   logic signed [TRIG_W-1:0] sin_second;
   logic signed [TRIG_W-1:0] cos_second;

   modport source (output valid, req_type, scale_factor, sin_first, cos_first,
                   sin_second, cos_second, input ready);
   modport sink (input valid, req_type, scale_factor, sin_first, cos_first,
                 sin_second, cos_second, output ready);
endinterface

`default_nettype wire

@@ sv/wvt_rsp_if.sv @@
`default_nettype none

interface wvt_rsp_if import wvt_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [POINT_W-1:0] point_x;
   logic signed [POINT_W-1:0] point_y;
   logic                      last_point;

   modport source (output valid, point_x, point_y, last_point, input ready);
   modport sink (input valid, point_x, point_y, last_point, output ready);
endinterface

`default_nettype wire

@@ sv/wvt_ctrl.sv @@
`default_nettype none

module wvt_ctrl import wvt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_type,
   output logic       req_ready,
   input  logic       shape_select,
   input  status_type status,
   output cmd_type    cmd
);

   state_type         state_ff, state_in;
   step_type          step_ff, step_in;
   logic [VIDX_W-1:0] vidx_ff, vidx_in;
   logic [K_W-1:0]    k_ff, k_in;
   logic              frame_ff, frame_in;

   logic              last_vertex;
   logic              last_point;

   assign last_vertex = ({1'b0, vidx_ff} == vertex_count(shape_select) - VCNT_W'(1));
   assign last_point  = (k_ff == point_count(shape_select) - K_W'(1));

   // next state and counters
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      vidx_in  = vidx_ff;
      k_in     = k_ff;
      frame_in = frame_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               step_in  = STEP_SCALE_X;
               vidx_in  = '0;
               k_in     = '0;
               frame_in = (req_type == REQ_FRAME);
               state_in = (req_type == REQ_FRAME) ? ST_XFORM : ST_LOAD;
            end
         end
         ST_LOAD: begin
            state_in = ST_XFORM;
         end
         ST_XFORM: begin
            if (step_ff == STEP_ROT2_YS) begin
               step_in = STEP_SCALE_X;
               vidx_in = vidx_ff + VIDX_W'(1);
               if (last_vertex) state_in = ST_DRAIN;
            end else begin
               step_in = step_type'(step_ff + 4'd1);
            end
         end
         ST_DRAIN: begin
            state_in = frame_ff ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               k_in = k_ff + K_W'(1);
               if (last_point) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // commands to the datapath
   always_comb begin
      cmd           = '0;
      cmd.opa       = OPA_MEM_X;
      cmd.opb       = OPB_SCALE;
      cmd.acc_op    = ACC_NONE;
      cmd.wb        = WB_NONE;
      cmd.vidx      = vidx_ff;
      cmd.emit_k    = k_ff;
      cmd.emit_last = last_point;
      req_ready     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_LOAD: begin
            cmd.load_unit = 1'b1;
         end
         ST_XFORM: begin
            unique case (step_ff)
               STEP_SCALE_X: begin
                  cmd.opa = OPA_MEM_X; cmd.opb = OPB_SCALE;
                  cmd.acc_op = ACC_LOAD; cmd.wb = WB_WX;
               end
               STEP_SCALE_Y: begin
                  cmd.opa = OPA_MEM_Y; cmd.opb = OPB_SCALE;
                  cmd.acc_op = ACC_LOAD; cmd.wb = WB_WY;
               end
               STEP_SCALE_Z: begin
                  cmd.opa = OPA_MEM_Z; cmd.opb = OPB_SCALE;
                  cmd.acc_op = ACC_LOAD; cmd.wb = WB_WZ;
               end
               STEP_ROT1_XC: begin
                  cmd.opa = OPA_WX; cmd.opb = OPB_COS1; cmd.acc_op = ACC_LOAD;
               end
               STEP_ROT1_ZS: begin
                  cmd.opa = OPA_WZ; cmd.opb = OPB_SIN1;
                  cmd.acc_op = ACC_SUB; cmd.wb = WB_MEM_X;
               end
               STEP_ROT1_ZC: begin
                  cmd.opa = OPA_WZ; cmd.opb = OPB_COS1; cmd.acc_op = ACC_LOAD;
               end
               STEP_ROT1_XS: begin
                  // first-axis z goes back into wz for the second rotation
                  cmd.opa = OPA_WX; cmd.opb = OPB_SIN1;
                  cmd.acc_op = ACC_ADD; cmd.wb = WB_WZ;
               end
               STEP_ROT2_YC: begin
                  cmd.opa = OPA_WY; cmd.opb = OPB_COS2; cmd.acc_op = ACC_LOAD;
               end
               STEP_ROT2_ZS: begin
                  cmd.opa = OPA_WZ; cmd.opb = OPB_SIN2;
                  cmd.acc_op = ACC_SUB; cmd.wb = WB_MEM_Y;
               end
               STEP_ROT2_ZC: begin
                  cmd.opa = OPA_WZ; cmd.opb = OPB_COS2; cmd.acc_op = ACC_LOAD;
               end
               STEP_ROT2_YS: begin
                  cmd.opa = OPA_WY; cmd.opb = OPB_SIN2;
                  cmd.acc_op = ACC_ADD; cmd.wb = WB_MEM_Z;
               end
               default: cmd.acc_op = ACC_NONE;
            endcase
         end
         ST_DRAIN: begin
            cmd.acc_op = ACC_NONE;
         end
         ST_EMIT: begin
            cmd.emit = status.out_free;
         end
         default: req_ready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= STEP_SCALE_X;
         vidx_ff  <= '0;
         k_ff     <= '0;
         frame_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         vidx_ff  <= vidx_in;
         k_ff     <= k_in;
         frame_ff <= frame_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/wvt_dp.sv @@
`default_nettype none

module wvt_dp import wvt_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  cmd_type                   cmd,
   output status_type                status,
   input  logic                      shape_select,
   input  logic [CENTER_W-1:0]       offset_x,
   input  logic [CENTER_W-1:0]       offset_y,
   input  logic [SCALE_W-1:0]        scale_factor,
   input  logic signed [TRIG_W-1:0]  sin_first,
   input  logic signed [TRIG_W-1:0]  cos_first,
   input  logic signed [TRIG_W-1:0]  sin_second,
   input  logic signed [TRIG_W-1:0]  cos_second,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [POINT_W-1:0] point_x,
   output logic signed [POINT_W-1:0] point_y,
   output logic                      last_point
);

   function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [ACC_W-1:0] v);
      logic [ACC_W-COORD_W:0] hi;
      logic signed [COORD_W-1:0] r;
      hi = v[ACC_W-1:COORD_W-1];
      if ((&hi) || !(|hi)) r = v[COORD_W-1:0];
      else if (v[ACC_W-1]) r = {1'b1, {(COORD_W-1){1'b0}}};
      else                 r = {1'b0, {(COORD_W-1){1'b1}}};
      return r;
   endfunction

   // floor of v plus the center, stepped toward zero when negative with a fraction left
   function automatic logic signed [POINT_W-1:0] to_screen(input logic signed [COORD_W-1:0] v,
                                                           input logic [CENTER_W-1:0] c);
      logic signed [COORD_W-1:0] sh;
      logic signed [SCR_W-1:0]   fl;
      logic [SCR_W-POINT_W:0]    hi;
      logic signed [POINT_W-1:0] r;
      sh = v >>> COORD_FRAC_BITS;
      fl = sh[SCR_W-1:0];
      fl = fl + SCR_W'(c);
      if (fl[SCR_W-1] && (|v[COORD_FRAC_BITS-1:0])) fl = fl + SCR_W'(1);
      hi = fl[SCR_W-1:POINT_W-1];
      if ((&hi) || !(|hi)) r = fl[POINT_W-1:0];
      else if (fl[SCR_W-1]) r = {1'b1, {(POINT_W-1){1'b0}}};
      else                  r = {1'b0, {(POINT_W-1){1'b1}}};
      return r;
   endfunction

   logic [SCALE_W-1:0]        scale_ff;
   logic signed [TRIG_W-1:0]  sin1_ff, cos1_ff, sin2_ff, cos2_ff;

   logic signed [COORD_W-1:0] x_mem_ff [MAX_VERTICES];
   logic signed [COORD_W-1:0] y_mem_ff [MAX_VERTICES];
   logic signed [COORD_W-1:0] z_mem_ff [MAX_VERTICES];
   unit_type                  unit_tab [MAX_VERTICES];

   logic signed [COORD_W-1:0] wx_ff, wy_ff, wz_ff;

   logic [LINK_W-1:0]         link;
   logic [VIDX_W-1:0]         rd_idx;
   logic                      rd_ok;
   logic signed [COORD_W-1:0] rd_x, rd_y, rd_z;

   logic signed [COORD_W-1:0] opa_val;
   logic signed [OPB_W-1:0]   opb_val;
   logic signed [PROD_W-1:0]  prod_in, prod_ff;
   logic                      scale_p_ff;
   acc_op_type                acc_op_p_ff;
   wb_type                    wb_p_ff;
   logic [VIDX_W-1:0]         idx_p_ff;

   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [ACC_W-1:0]   prod_ext;
   logic signed [ACC_W-1:0]   shifted;
   logic signed [COORD_W-1:0] wb_val;

   logic                      rsp_valid_ff;
   logic signed [POINT_W-1:0] point_x_ff, point_y_ff;
   logic                      last_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         scale_ff <= scale_factor;
         sin1_ff  <= sin_first;
         cos1_ff  <= cos_first;
         sin2_ff  <= sin_second;
         cos2_ff  <= cos_second;
      end
   end

   // one read address: vertex under transform, or edge endpoint while emitting
   assign link   = link_vertex(shape_select, cmd.emit_k);
   assign rd_idx = cmd.emit ? link[VIDX_W-1:0] : cmd.vidx;
   assign rd_ok  = !cmd.emit || (int'(link) < MAX_VERTICES);
   assign rd_x   = rd_ok ? x_mem_ff[rd_idx] : '0;
   assign rd_y   = rd_ok ? y_mem_ff[rd_idx] : '0;
   assign rd_z   = rd_ok ? z_mem_ff[rd_idx] : '0;

   always_comb begin
      for (int i = 0; i < MAX_VERTICES; i++)
         unit_tab[i] = unit_vertex(shape_select, LINK_W'(i));
   end

   always_comb begin
      case (cmd.opa)
         OPA_MEM_X: opa_val = rd_x;
         OPA_MEM_Y: opa_val = rd_y;
         OPA_MEM_Z: opa_val = rd_z;
         OPA_WX:    opa_val = wx_ff;
         OPA_WY:    opa_val = wy_ff;
         OPA_WZ:    opa_val = wz_ff;
         default:   opa_val = '0;
      endcase
   end

   always_comb begin
      case (cmd.opb)
         OPB_SCALE: opb_val = {1'b0, scale_ff};
         OPB_COS1:  opb_val = OPB_W'(cos1_ff);
         OPB_SIN1:  opb_val = OPB_W'(sin1_ff);
         OPB_COS2:  opb_val = OPB_W'(cos2_ff);
         OPB_SIN2:  opb_val = OPB_W'(sin2_ff);
         default:   opb_val = '0;
      endcase
   end

   assign prod_in = opa_val * opb_val;

   // product stage
   always_ff @(posedge clock) begin
      prod_ff    <= prod_in;
      scale_p_ff <= (cmd.opb == OPB_SCALE);
      idx_p_ff   <= cmd.vidx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_op_p_ff <= ACC_NONE;
         wb_p_ff     <= WB_NONE;
      end else begin
         acc_op_p_ff <= cmd.acc_op;
         wb_p_ff     <= cmd.wb;
      end
   end

   // accumulate stage
   assign prod_ext = ACC_W'(prod_ff);

   always_comb begin
      case (acc_op_p_ff)
         ACC_LOAD: acc_in = prod_ext;
         ACC_ADD:  acc_in = acc_ff + prod_ext;
         ACC_SUB:  acc_in = acc_ff - prod_ext;
         default:  acc_in = acc_ff;
      endcase
   end

   assign shifted = scale_p_ff ? (acc_in >>> SCALE_FRAC_BITS) : (acc_in >>> TRIG_FRAC_BITS);
   assign wb_val  = sat_coord(shifted);

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (wb_p_ff == WB_WX) wx_ff <= wb_val;
      if (wb_p_ff == WB_WY) wy_ff <= wb_val;
      if (wb_p_ff == WB_WZ) wz_ff <= wb_val;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_VERTICES; i++) begin
            x_mem_ff[i] <= '0;
            y_mem_ff[i] <= '0;
            z_mem_ff[i] <= '0;
         end
      end else if (cmd.load_unit) begin
         for (int i = 0; i < MAX_VERTICES; i++) begin
            x_mem_ff[i] <= COORD_W'(unit_tab[i].x) <<< COORD_FRAC_BITS;
            y_mem_ff[i] <= COORD_W'(unit_tab[i].y) <<< COORD_FRAC_BITS;
            z_mem_ff[i] <= COORD_W'(unit_tab[i].z) <<< COORD_FRAC_BITS;
         end
      end else begin
         if (wb_p_ff == WB_MEM_X) x_mem_ff[idx_p_ff] <= wb_val;
         if (wb_p_ff == WB_MEM_Y) y_mem_ff[idx_p_ff] <= wb_val;
         if (wb_p_ff == WB_MEM_Z) z_mem_ff[idx_p_ff] <= wb_val;
      end
   end

   // result register: take a new beat when empty or being drained
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         point_x_ff <= to_screen(rd_x, offset_x);
         point_y_ff <= to_screen(rd_y, offset_y);
         last_ff    <= cmd.emit_last;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign point_x    = point_x_ff;
   assign point_y    = point_y_ff;
   assign last_point = last_ff;

endmodule

`default_nettype wire

@@ sv/wireframe_vertex_transform.sv @@
// A frame item transforms its N stored vertices (N = 8 cube, 5 pyramid), then gives
// one point a cycle while the sink takes them (24 or 16 points).
// A load item first reloads the unit vertices, transforms them and gives no points.
// A new item is taken only once the last one is done; one shared multiply-accumulate
// unit forms the 11 products per vertex, one per cycle.
// Reset: synchronous; control and CSR registers return to defaults and all stored vertices to zero.
`default_nettype none

module wireframe_vertex_transform import wvt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   wvt_req_if.sink               req_chan,
   wvt_rsp_if.source             rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic                  shape_ff;
   logic [CENTER_W-1:0]   offset_x_ff, offset_y_ff;
   logic [CSR_IDX_W-1:0]  reg_idx;
   logic                  csr_write;

   cmd_type               cmd;
   status_type            status;
   logic                  req_ready;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         shape_ff    <= SHAPE_CUBE;
         offset_x_ff <= OFFSET_X_RESET;
         offset_y_ff <= OFFSET_Y_RESET;
      end else if (csr_write) begin
         unique case (reg_idx)
            REG_SHAPE_SELECT: shape_ff    <= csr_pwdata[0];
            REG_OFFSET_X:     offset_x_ff <= csr_pwdata[CENTER_W-1:0];
            REG_OFFSET_Y:     offset_y_ff <= csr_pwdata[CENTER_W-1:0];
            default:          shape_ff    <= shape_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_SHAPE_SELECT: csr_prdata = CSR_DATA_W'(shape_ff);
         REG_OFFSET_X:     csr_prdata = CSR_DATA_W'(offset_x_ff);
         REG_OFFSET_Y:     csr_prdata = CSR_DATA_W'(offset_y_ff);
         default:          csr_prdata = '0;
      endcase
   end

   wvt_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_chan.valid),
      .req_type     (req_chan.req_type),
      .req_ready    (req_ready),
      .shape_select (shape_ff),
      .status       (status),
      .cmd          (cmd)
   );

   wvt_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .shape_select (shape_ff),
      .offset_x     (offset_x_ff),
      .offset_y     (offset_y_ff),
      .scale_factor (req_chan.scale_factor),
      .sin_first    (req_chan.sin_first),
      .cos_first    (req_chan.cos_first),
      .sin_second   (req_chan.sin_second),
      .cos_second   (req_chan.cos_second),
      .rsp_valid    (rsp_chan.valid),
      .rsp_ready    (rsp_chan.ready),
      .point_x      (rsp_chan.point_x),
      .point_y      (rsp_chan.point_y),
      .last_point   (rsp_chan.last_point)
   );

   assign req_chan.ready = req_ready;

   // an accepted item keeps the input closed while it is worked on
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("input still open right after an accepted beat");

   // nothing follows the final point of a frame
   a_quiet_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && rsp_chan.last_point) |=> !rsp_chan.valid)
      else $error("result beat right after the last point");

   // mid-frame points only while the input is closed
   a_closed_mid_frame: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.last_point) |-> !req_chan.ready)
      else $error("input open while a frame is still emitting");

endmodule

`default_nettype wire
